/* rtl/ffba_pkg.sv */
// Package: widths, constants, codes and shared types of the block allocator.
`timescale 1ns / 1ps
package ffba_pkg;
    localparam int MAX_BLOCKS   = 256;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 32;
    localparam logic [26:0] SIZE_CAP = 27'd100000000;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_RESIZE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_UNKNOWN  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_HEAP_BASE   = 2'd0,
        CFG_HEAP_LIMIT  = 2'd1,
        CFG_MAX_REQUEST = 2'd2
    } t_cfg;

    typedef struct packed {
        logic [26:0] bytes;
        logic [31:0] offset;
        logic        is_free;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;
endpackage

/* rtl/ffba_table.sv */
// Block table: one synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps
module ffba_table (
    input  logic              i_clk,
    input  ffba_pkg::t_mem_req i_req,
    output ffba_pkg::t_entry  o_rdata
);
    ffba_pkg::t_entry r_mem [ffba_pkg::MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

/* rtl/first_fit_block_allocator_core.sv */
// Top level: first-fit heap block allocator with table scan sequencer.
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// s_axis   in   tvalid/tready        tuser=req_type, tdata=req_size,req_addr
// m_axis   out  tvalid/tready        tuser=status, tdata=result fields
// cfg      in   i_cfg_we             i_cfg_index, i_cfg_data
// A request scans the table one entry a cycle through the memory read port.
// Reset clears the counters, state and configuration, not the table; the table needs no clearing.
// A held result does not block the next request from being accepted; the next
// result waits in S_OUT until the held beat leaves.
module first_fit_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // req_size[26:0], req_addr[58:27]
    input  logic [1:0]  i_s_axis_tuser,  // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // result_addr[31:0], copy_bytes[58:32], free_block_count[67:59],
    // free_byte_count[99:68], total_block_count[108:100], total_byte_count[140:109]
    output logic [143:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser   // status
);
    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;
    localparam logic [31:0] HDR = 32'(ffba_pkg::HEADER_BYTES);

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_FIT, S_ACT, S_OUT} t_state;

    logic [31:0] r_base, r_limit;
    logic [26:0] r_maxreq;
    t_state r_state;
    logic [1:0] r_type;
    logic [26:0] r_size;
    logic [31:0] r_addr;
    logic [CW-1:0] r_ptr;
    logic r_pend;          // read issued last cycle
    logic [IW-1:0] r_pidx;
    logic r_found;
    logic [IW-1:0] r_fidx;
    ffba_pkg::t_entry r_fent;
    logic [CW-1:0] r_total, r_fblk;
    logic [31:0] r_top, r_fbytes, r_used;
    logic r_ovalid;
    logic [1:0] r_ost;
    logic [31:0] r_oaddr;
    logic [26:0] r_ocopy;
    logic [1:0] r_m_st;
    logic [31:0] r_m_addr;
    logic [26:0] r_m_copy;
    logic [CW-1:0] r_m_fblk, r_m_total;
    logic [31:0] r_m_fbytes, r_m_used;

    ffba_pkg::t_mem_req w_req;
    ffba_pkg::t_entry w_rd;

    ffba_table u_table (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rd));

    logic [26:0] w_lim;
    logic [31:0] w_real;
    logic [31:0] w_rd_addr;
    logic [26:0] w_rd_pay;
    logic [32:0] w_grow;
    logic w_bad;
    assign w_lim = (r_maxreq < ffba_pkg::SIZE_CAP) ? r_maxreq : ffba_pkg::SIZE_CAP;
    assign w_real = {5'd0, r_size} + HDR;
    assign w_rd_addr = r_base + w_rd.offset + HDR;
    assign w_rd_pay = w_rd.bytes - HDR[26:0];
    assign w_grow = {1'b0, r_top} + {1'b0, w_real};
    assign w_bad = (r_size == 27'd0) || (r_size > w_lim);

    logic w_scan_more;
    assign w_scan_more = r_ptr < r_total;

    logic [26:0] r_fpay;
    logic r_wr;
    logic [IW-1:0] r_wa;
    ffba_pkg::t_entry r_wd;

    always_comb begin
        w_req.we = r_wr;
        w_req.waddr = r_wa;
        w_req.wdata = r_wd;
        w_req.raddr = r_ptr[IW-1:0];
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser = r_m_st;
    assign o_m_axis_tdata = {3'd0, r_m_used, r_m_total, r_m_fbytes, r_m_fblk, r_m_copy,
                             r_m_addr};

    // request sequencer: config writes, table scans, result for a free-fit hit or an append, and output
    always_ff @(posedge i_clk) begin
        r_wr <= 1'b0;
        if (!i_rst_n) begin
            r_base <= 32'd0; r_limit <= 32'd1048576; r_maxreq <= 27'd100000000;
            r_state <= S_IDLE; r_total <= '0; r_top <= '0; r_fblk <= '0;
            r_fbytes <= '0; r_used <= '0; r_ovalid <= 1'b0; r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffba_pkg::CFG_HEAP_BASE:   r_base <= i_cfg_data;
                    ffba_pkg::CFG_HEAP_LIMIT:  r_limit <= i_cfg_data;
                    ffba_pkg::CFG_MAX_REQUEST: r_maxreq <= i_cfg_data[26:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_axis_tready && r_state != S_OUT) r_ovalid <= 1'b0;
            r_pend <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid && o_s_axis_tready) begin
                        r_type <= i_s_axis_tuser;
                        r_size <= i_s_axis_tdata[26:0];
                        r_addr <= i_s_axis_tdata[58:27];
                        r_ptr <= '0; r_found <= 1'b0; r_ocopy <= '0; r_oaddr <= '0;
                        r_ost <= ffba_pkg::ST_OK;
                        case (ffba_pkg::t_req'(i_s_axis_tuser))
                            ffba_pkg::REQ_ALLOC: r_state <= S_FIT;
                            ffba_pkg::REQ_FREE:
                                r_state <= (i_s_axis_tdata[58:27] == 32'd0) ? S_OUT : S_FIND;
                            ffba_pkg::REQ_RESIZE:
                                r_state <= (i_s_axis_tdata[58:27] == 32'd0) ? S_FIT : S_FIND;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_FIND: begin
                    if (r_pend && w_rd_addr == r_addr) begin
                        r_found <= 1'b1; r_fidx <= r_pidx; r_fent <= w_rd;
                        r_fpay <= w_rd_pay;
                        r_state <= S_ACT;
                    end else if (w_scan_more) begin
                        r_pend <= 1'b1; r_pidx <= r_ptr[IW-1:0]; r_ptr <= r_ptr + 1'b1;
                    end else if (!r_pend) begin
                        r_ost <= ffba_pkg::ST_UNKNOWN; r_state <= S_OUT;
                    end
                end
                S_ACT: begin
                    r_ptr <= '0;
                    if (r_type == ffba_pkg::REQ_FREE) begin
                        if (!r_fent.is_free) begin
                            r_wr <= 1'b1; r_wa <= r_fidx;
                            r_wd <= '{bytes: r_fent.bytes, offset: r_fent.offset, is_free: 1'b1};
                            r_fblk <= r_fblk + 1'b1; r_fbytes <= r_fbytes + {5'd0, r_fpay};
                        end
                        r_state <= S_OUT;
                    end else if (r_fent.is_free) begin
                        r_ost <= ffba_pkg::ST_UNKNOWN; r_state <= S_OUT;
                    end else if (r_fpay >= r_size) begin
                        r_oaddr <= r_addr; r_state <= S_OUT;
                    end else begin
                        r_state <= S_FIT;
                    end
                end
                S_FIT: begin
                    if (w_bad) begin
                        r_ost <= ffba_pkg::ST_BAD_SIZE; r_state <= S_OUT;
                    end else if (r_pend && w_rd.is_free && {5'd0, w_rd.bytes} >= w_real) begin
                        r_wr <= 1'b1; r_wa <= r_pidx;
                        r_wd <= '{bytes: w_rd.bytes, offset: w_rd.offset, is_free: 1'b0};
                        r_fblk <= r_fblk - 1'b1; r_fbytes <= r_fbytes - {5'd0, w_rd_pay};
                        r_oaddr <= w_rd_addr;
                        r_state <= r_found ? S_ACT : S_OUT;
                        r_type <= ffba_pkg::REQ_FREE;
                        if (r_found) r_ocopy <= r_fpay;
                    end else if (w_scan_more) begin
                        r_pend <= 1'b1; r_pidx <= r_ptr[IW-1:0]; r_ptr <= r_ptr + 1'b1;
                    end else if (!r_pend) begin
                        if (r_total >= CW'(ffba_pkg::MAX_BLOCKS) || w_grow > {1'b0, r_limit}) begin
                            r_ost <= ffba_pkg::ST_NO_MEM; r_state <= S_OUT;
                        end else begin
                            r_wr <= 1'b1; r_wa <= r_total[IW-1:0];
                            r_wd <= '{bytes: w_real[26:0], offset: r_top, is_free: 1'b0};
                            r_total <= r_total + 1'b1; r_top <= w_grow[31:0];
                            r_used <= r_used + {5'd0, r_size};
                            r_oaddr <= r_base + r_top + HDR;
                            r_state <= r_found ? S_ACT : S_OUT;
                            r_type <= ffba_pkg::REQ_FREE;
                            if (r_found) r_ocopy <= r_fpay;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_m_st <= r_ost; r_m_addr <= r_oaddr; r_m_copy <= r_ocopy;
                        r_m_fblk <= r_fblk; r_m_fbytes <= r_fbytes;
                        r_m_total <= r_total; r_m_used <= r_used;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("held beat changed");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_ovalid) else $error("result lost");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fblk <= r_total) else $error("free count above total");
endmodule
